### rtl/core/bd3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bd3_pkg
// Shared register indexes, widths and reset values of the binarize and
// dilate unit.
// ----------------------------------------------------------------------------
package bd3_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BINARY_LEVEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

    localparam logic       RST_COLOR_MODE   = 1'b0;
    localparam logic [7:0] RST_BINARY_LEVEL = 8'd100;
    localparam int         RST_IMAGE_WIDTH  = 640;
    localparam int         RST_IMAGE_HEIGHT = 480;

    // window bit masks: bits 0..2 right column, 3..5 center, 6..8 left
    localparam logic [8:0] WIN_LEFT_COL   = 9'h1C0;
    localparam logic [8:0] WIN_RIGHT_COL  = 9'h007;
    localparam logic [8:0] WIN_TOP_ROW    = 9'h049;
    localparam logic [8:0] WIN_BOTTOM_ROW = 9'h124;

    // entry of the line memory
    typedef struct packed {
        logic two_above;
        logic above;
    } t_line_entry;

endpackage
`default_nettype wire

### rtl/core/bd3_line_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bd3_line_buf
// Two-row mask line memory, one read and one write per cycle, registered
// read data with write-to-read forwarding on the same entry.
// ----------------------------------------------------------------------------
module bd3_line_buf #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire                        i_clk,
    input  wire                        i_rd_en,
    input  wire [AW-1:0]               i_rd_addr,
    output bd3_pkg::t_line_entry       o_rd_data,
    input  wire                        i_wr_en,
    input  wire [AW-1:0]               i_wr_addr,
    input  wire bd3_pkg::t_line_entry  i_wr_data
);

    bd3_pkg::t_line_entry r_mem [DEPTH];
    bd3_pkg::t_line_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            // same entry written this cycle: take the new value
            if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### rtl/core/binarize_and_dilate_3x3_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binarize_and_dilate_3x3_unit
// Thresholds one color channel of a raster pixel stream into a mask and
// applies a 3x3 dilation, output one row plus one pixel behind the input.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | sink      | i_in_valid / o_in_stall | kind, green, red
//  out     | source    | o_out_valid/i_out_stall | mask_bit, end_of_row, end_of_frame
//  cfg     | sink      | i_cfg_we                | i_cfg_idx, i_cfg_data
//
//  one beat per cycle in and out while the output is not stalled
//  a result is registered in the work stage, then in the output register
//  the line memory read for a beat is issued at accept, the write-back when the
//  beat leaves the work stage; the single memory port pair sets the rate
//  reset clears counters, window and handshake state; line memory is not cleared
//  an output stall holds the work stage and stalls the input
// ----------------------------------------------------------------------------
module binarize_and_dilate_3x3_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire                               i_in_kind,
    input  wire [7:0]                         i_in_green,
    input  wire [7:0]                         i_in_red,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic                              o_out_mask_bit,
    output logic                              o_out_end_of_row,
    output logic                              o_out_end_of_frame,
    input  wire                               i_cfg_we,
    input  wire [bd3_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire [bd3_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HR = $clog2(MAX_HEIGHT);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 3);

    typedef struct packed {
        logic       mbit;
        logic       emit;
        logic       eor;
        logic       eof;
        logic [8:0] keep;
    } t_stage;

    // configuration
    logic          r_color_mode;
    logic [7:0]    r_level;
    logic [WW-1:0] r_w_lim;
    logic [HW-1:0] r_h_lim;

    // stream position
    logic [CW-1:0] r_in_col, n_in_col;
    logic [RW-1:0] r_in_row, n_in_row;
    logic [CW-1:0] r_out_col, n_out_col;
    logic [HR-1:0] r_out_row, n_out_row;

    // work stage and window
    logic          r_b_valid;
    t_stage        r_b;
    t_stage        n_b;
    logic [CW-1:0] r_b_addr;
    logic [8:0]    r_win;
    logic [8:0]    win_new;

    // output register
    logic          r_out_valid;
    logic          r_out_mask;
    logic          r_out_eor;
    logic          r_out_eof;

    logic          in_acc;
    logic          b_go;
    logic          cfg_geom;
    logic [WW-1:0] w_cfg;
    logic [HW-1:0] h_cfg;
    logic [7:0]    chan;
    logic          out_col_last;
    logic          out_row_last;
    logic          in_col_last;

    bd3_pkg::t_line_entry rd_data;
    bd3_pkg::t_line_entry wr_data;

    assign b_go       = r_b_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_b_valid && !b_go;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign cfg_geom   = i_cfg_we && ((i_cfg_idx == bd3_pkg::CFG_IMAGE_WIDTH) ||
                                     (i_cfg_idx == bd3_pkg::CFG_IMAGE_HEIGHT));

    // dimension clamp: zero counts as one, above the maximum counts as the maximum
    always_comb begin
        if (i_cfg_data == '0) begin
            w_cfg = WW'(1);
            h_cfg = HW'(1);
        end else begin
            w_cfg = (32'(i_cfg_data) > MAX_WIDTH)  ? WW'(MAX_WIDTH)  : WW'(i_cfg_data);
            h_cfg = (32'(i_cfg_data) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_mode <= bd3_pkg::RST_COLOR_MODE;
            r_level      <= bd3_pkg::RST_BINARY_LEVEL;
            r_w_lim      <= (bd3_pkg::RST_IMAGE_WIDTH > MAX_WIDTH) ?
                            WW'(MAX_WIDTH) : WW'(bd3_pkg::RST_IMAGE_WIDTH);
            r_h_lim      <= (bd3_pkg::RST_IMAGE_HEIGHT > MAX_HEIGHT) ?
                            HW'(MAX_HEIGHT) : HW'(bd3_pkg::RST_IMAGE_HEIGHT);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bd3_pkg::CFG_COLOR_MODE:   r_color_mode <= i_cfg_data[0];
                bd3_pkg::CFG_BINARY_LEVEL: r_level      <= i_cfg_data[7:0];
                bd3_pkg::CFG_IMAGE_WIDTH:  r_w_lim      <= w_cfg;
                bd3_pkg::CFG_IMAGE_HEIGHT: r_h_lim      <= h_cfg;
                default: ;
            endcase
        end
    end

    // position bookkeeping and window masks are settled at accept
    always_comb begin
        chan         = r_color_mode ? i_in_red : i_in_green;
        out_col_last = (WW'(r_out_col) + WW'(1)) >= r_w_lim;
        out_row_last = (HW'(r_out_row) + HW'(1)) >= r_h_lim;
        in_col_last  = (WW'(r_in_col) + WW'(1)) >= r_w_lim;

        n_b.mbit = !i_in_kind && (chan > r_level);
        n_b.emit = (r_in_row > RW'(1)) || ((r_in_row == RW'(1)) && (r_in_col != '0));
        n_b.eor  = out_col_last;
        n_b.eof  = n_b.emit && out_col_last && out_row_last;
        n_b.keep = 9'h1FF;
        if (r_out_col == '0) n_b.keep = n_b.keep & ~bd3_pkg::WIN_LEFT_COL;
        if (out_col_last)    n_b.keep = n_b.keep & ~bd3_pkg::WIN_RIGHT_COL;
        if (r_out_row == '0) n_b.keep = n_b.keep & ~bd3_pkg::WIN_TOP_ROW;
        if (out_row_last)    n_b.keep = n_b.keep & ~bd3_pkg::WIN_BOTTOM_ROW;

        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (n_b.emit) begin
            if (out_col_last) begin
                n_out_col = '0;
                n_out_row = r_out_row + HR'(1);
            end else begin
                n_out_col = r_out_col + CW'(1);
            end
        end

        n_in_col = r_in_col + CW'(1);
        n_in_row = r_in_row;
        if (in_col_last) begin
            n_in_col = '0;
            // row count parks three past the last row
            if ((RW'(r_h_lim) + RW'(2)) > r_in_row) n_in_row = r_in_row + RW'(1);
        end

        if (n_b.eof) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (cfg_geom) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (in_acc) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (in_acc) begin
            r_b_valid <= 1'b1;
        end else if (b_go) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_b      <= n_b;
            r_b_addr <= r_in_col;
        end
    end

    bd3_line_buf #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_in_col),
        .o_rd_data (rd_data),
        .i_wr_en   (b_go),
        .i_wr_addr (r_b_addr),
        .i_wr_data (wr_data)
    );

    // rows shift down by one in the line memory
    always_comb begin
        wr_data.two_above = rd_data.above;
        wr_data.above     = r_b.mbit;
        win_new = {r_win[5:0], r_b.mbit, rd_data.above, rd_data.two_above};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (cfg_geom) begin
            r_win <= '0;
        end else if (b_go) begin
            r_win <= r_b.eof ? 9'h000 : win_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_go && r_b.emit) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go && r_b.emit) begin
            r_out_mask <= |(win_new & r_b.keep);
            r_out_eor  <= r_b.eor;
            r_out_eof  <= r_b.eof;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_mask_bit     = r_out_mask;
    assign o_out_end_of_row   = r_out_eor;
    assign o_out_end_of_frame = r_out_eof;

    a_stall_needs_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_b_valid)
        else $error("input stalled with empty work stage");

    a_eof_is_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_end_of_frame || o_out_end_of_row))
        else $error("end of frame without end of row");

    a_emit_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_go && r_b.emit) |=> o_out_valid)
        else $error("emitted beat lost");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WW'(r_in_col) < r_w_lim))
        else $error("input column past row width");

endmodule
`default_nettype wire
